// File: src/i2cram_pkg.sv
`timescale 1ns / 1ps

package i2cram_pkg;

  localparam int WORD_BYTES = 4;
  localparam int CNT_W      = $clog2(WORD_BYTES + 1);
  localparam int SPAN_W     = 7;
  localparam int PADDR_W    = 4;

  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_DEVICE = 2'd1;
  localparam logic [1:0] ST_ADDR_NACK = 2'd2;
  localparam logic [1:0] ST_DATA_NACK = 2'd3;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] reg_addr;
    logic [31:0] write_data;
    logic        sda_in;
  } cmd_t;

  typedef struct packed {
    logic        scl_low;
    logic        sda_low;
    logic        busy_res;
    logic        done_res;
    logic [1:0]  status;
    logic [31:0] read_data;
  } res_t;

  typedef struct packed {
    logic [7:0] device_address;
    logic [1:0] address_bytes;
    logic [1:0] data_bytes;
    logic [1:0] speed_select;
  } cfg_t;

  function automatic logic [SPAN_W-1:0] speed_span(input logic [1:0] sel);
    logic [SPAN_W-1:0] span;
    case (sel)
      2'd0:    span = SPAN_W'(126);
      2'd1:    span = SPAN_W'(51);
      2'd2:    span = SPAN_W'(4);
      default: span = SPAN_W'(1);
    endcase
    return span;
  endfunction

  function automatic logic [CNT_W-1:0] clamp_len(input logic [1:0] f);
    logic [2:0] n;
    n = {1'b0, f} + 3'd1;
    if (int'(n) > WORD_BYTES) begin
      return CNT_W'(WORD_BYTES);
    end
    return CNT_W'(n);
  endfunction

  function automatic logic [7:0] pick_byte(input logic [31:0] word,
                                           input logic [CNT_W-1:0] count,
                                           input logic [CNT_W-1:0] k);
    logic [7:0]  d;
    logic [31:0] sh;
    d  = 8'(count) - 8'd1 - 8'(k);
    sh = word >> {d[2:0], 3'b000};
    return sh[7:0];
  endfunction

endpackage

// File: src/i2cram_cfg.sv
`timescale 1ns / 1ps

module i2cram_cfg
  import i2cram_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output cfg_t               cfg
);

  localparam logic [1:0] REG_DEVICE = 2'd0;
  localparam logic [1:0] REG_ABYTES = 2'd1;
  localparam logic [1:0] REG_DBYTES = 2'd2;
  localparam logic [1:0] REG_SPEED  = 2'd3;

  logic       wr_en;
  logic [1:0] reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_DEVICE: cfg.device_address <= pwdata[7:0];
        REG_ABYTES: cfg.address_bytes  <= pwdata[1:0];
        REG_DBYTES: cfg.data_bytes     <= pwdata[1:0];
        REG_SPEED:  cfg.speed_select   <= pwdata[1:0];
        default:    cfg.speed_select   <= cfg.speed_select;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_DEVICE: prdata = {24'd0, cfg.device_address};
      REG_ABYTES: prdata = {30'd0, cfg.address_bytes};
      REG_DBYTES: prdata = {30'd0, cfg.data_bytes};
      REG_SPEED:  prdata = {30'd0, cfg.speed_select};
      default:    prdata = '0;
    endcase
  end

endmodule

// File: src/i2cram_seq.sv
`timescale 1ns / 1ps

module i2cram_seq
  import i2cram_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic step,
  input  cmd_t cmd,
  input  cfg_t cfg,
  output res_t res_next
);

  localparam logic [3:0] PH_IDLE  = 4'd0;
  localparam logic [3:0] PH_ST_A  = 4'd1;
  localparam logic [3:0] PH_ST_B  = 4'd2;
  localparam logic [3:0] PH_ST_C  = 4'd3;
  localparam logic [3:0] PH_TX_LO = 4'd4;
  localparam logic [3:0] PH_TX_HI = 4'd5;
  localparam logic [3:0] PH_RX_LO = 4'd6;
  localparam logic [3:0] PH_RX_HI = 4'd7;
  localparam logic [3:0] PH_SP_A  = 4'd8;
  localparam logic [3:0] PH_SP_B  = 4'd9;
  localparam logic [3:0] PH_SP_C  = 4'd10;

  localparam logic [2:0] STG_DEV_W = 3'd0;
  localparam logic [2:0] STG_REG   = 3'd1;
  localparam logic [2:0] STG_DATA  = 3'd2;
  localparam logic [2:0] STG_DEV_R = 3'd3;
  localparam logic [2:0] STG_RX    = 3'd4;

  logic [3:0]        phase, phase_next;
  logic [SPAN_W-1:0] half_period_count, half_period_count_next;
  logic [3:0]        bit_index, bit_index_next;
  logic [CNT_W-1:0]  byte_index, byte_index_next;
  logic [7:0]        byte_shift, byte_shift_next;
  logic [31:0]       address_latch, address_latch_next;
  logic [31:0]       data_latch, data_latch_next;
  logic [31:0]       receive_accum, receive_accum_next;
  logic              is_read, is_read_next;
  logic [1:0]        last_status, last_status_next;
  logic [2:0]        stage, stage_next;
  logic [1:0]        pending, pending_next;
  logic [7:0]        act_dev, act_dev_next;
  logic [CNT_W-1:0]  act_nreg, act_nreg_next;
  logic [CNT_W-1:0]  act_ndata, act_ndata_next;
  logic [SPAN_W-1:0] act_span, act_span_next;
  logic              scl_drv, scl_drv_next;
  logic              sda_drv, sda_drv_next;
  logic [31:0]       read_word, read_word_next;
  logic              done;

  always_comb begin
    logic [SPAN_W-1:0] hpc_inc;
    logic [7:0]        shifted;
    logic [CNT_W-1:0]  bidx_inc;
    logic [7:0]        tx_byte;
    logic              tx_go;
    logic              rx_go;
    logic              stop_go;
    logic [1:0]        stop_code;

    phase_next             = phase;
    half_period_count_next = half_period_count;
    bit_index_next         = bit_index;
    byte_index_next        = byte_index;
    byte_shift_next        = byte_shift;
    address_latch_next     = address_latch;
    data_latch_next        = data_latch;
    receive_accum_next     = receive_accum;
    is_read_next           = is_read;
    last_status_next       = last_status;
    stage_next             = stage;
    pending_next           = pending;
    act_dev_next           = act_dev;
    act_nreg_next          = act_nreg;
    act_ndata_next         = act_ndata;
    act_span_next          = act_span;
    scl_drv_next           = scl_drv;
    sda_drv_next           = sda_drv;
    read_word_next         = read_word;
    done                   = 1'b0;
    hpc_inc                = half_period_count + SPAN_W'(1);
    shifted                = '0;
    bidx_inc               = byte_index + CNT_W'(1);
    tx_byte                = '0;
    tx_go                  = 1'b0;
    rx_go                  = 1'b0;
    stop_go                = 1'b0;
    stop_code              = ST_OK;

    if (phase == PH_IDLE) begin
      if (cmd.action == ACT_WRITE || cmd.action == ACT_READ) begin
        is_read_next           = (cmd.action == ACT_READ);
        address_latch_next     = cmd.reg_addr;
        data_latch_next        = cmd.write_data;
        receive_accum_next     = '0;
        act_dev_next           = cfg.device_address;
        act_nreg_next          = clamp_len(cfg.address_bytes);
        act_ndata_next         = clamp_len(cfg.data_bytes);
        act_span_next          = speed_span(cfg.speed_select);
        stage_next             = STG_DEV_W;
        pending_next           = ST_OK;
        byte_index_next        = '0;
        bit_index_next         = '0;
        half_period_count_next = '0;
        phase_next             = PH_ST_A;
      end
    end else if (hpc_inc < act_span) begin
      half_period_count_next = hpc_inc;
    end else begin
      half_period_count_next = '0;
      unique case (phase)
        PH_ST_A: begin
          scl_drv_next = 1'b0;
          sda_drv_next = 1'b0;
          phase_next   = PH_ST_B;
        end
        PH_ST_B: begin
          sda_drv_next = 1'b1;
          phase_next   = PH_ST_C;
        end
        PH_ST_C: begin
          scl_drv_next = 1'b1;
          tx_go        = 1'b1;
          tx_byte      = (stage == STG_DEV_R) ? {act_dev[7:1], 1'b1} : {act_dev[7:1], 1'b0};
        end
        PH_TX_LO: begin
          scl_drv_next = 1'b0;
          phase_next   = PH_TX_HI;
        end
        PH_TX_HI: begin
          scl_drv_next = 1'b1;
          if (bit_index < 4'd8) begin
            shifted         = {byte_shift[6:0], 1'b0};
            byte_shift_next = shifted;
            bit_index_next  = bit_index + 4'd1;
            sda_drv_next    = (bit_index < 4'd7) && !shifted[7];
            phase_next      = PH_TX_LO;
          end else if (cmd.sda_in) begin
            stop_go   = 1'b1;
            stop_code = (stage == STG_REG)  ? ST_ADDR_NACK :
                        (stage == STG_DATA) ? ST_DATA_NACK : ST_NO_DEVICE;
          end else begin
            unique case (stage)
              STG_DEV_W: begin
                stage_next      = STG_REG;
                byte_index_next = '0;
                tx_go           = 1'b1;
                tx_byte         = pick_byte(address_latch, act_nreg, '0);
              end
              STG_REG: begin
                byte_index_next = bidx_inc;
                if (bidx_inc < act_nreg) begin
                  tx_go   = 1'b1;
                  tx_byte = pick_byte(address_latch, act_nreg, bidx_inc);
                end else if (is_read) begin
                  stage_next = STG_DEV_R;
                  phase_next = PH_ST_A;
                end else begin
                  stage_next      = STG_DATA;
                  byte_index_next = '0;
                  tx_go           = 1'b1;
                  tx_byte         = pick_byte(data_latch, act_ndata, '0);
                end
              end
              STG_DATA: begin
                byte_index_next = bidx_inc;
                if (bidx_inc < act_ndata) begin
                  tx_go   = 1'b1;
                  tx_byte = pick_byte(data_latch, act_ndata, bidx_inc);
                end else begin
                  stop_go = 1'b1;
                end
              end
              default: begin
                stage_next      = STG_RX;
                byte_index_next = '0;
                rx_go           = 1'b1;
              end
            endcase
          end
        end
        PH_RX_LO: begin
          scl_drv_next = 1'b0;
          phase_next   = PH_RX_HI;
        end
        PH_RX_HI: begin
          scl_drv_next = 1'b1;
          if (bit_index < 4'd8) begin
            byte_shift_next = {byte_shift[6:0], cmd.sda_in};
            bit_index_next  = bit_index + 4'd1;
            if (bit_index == 4'd7) begin
              sda_drv_next = ({1'b0, byte_index} + 1'b1) < {1'b0, act_ndata};
            end
            phase_next = PH_RX_LO;
          end else begin
            receive_accum_next = {receive_accum[23:0], byte_shift};
            byte_index_next    = bidx_inc;
            if (bidx_inc < act_ndata) begin
              rx_go = 1'b1;
            end else begin
              stop_go = 1'b1;
            end
          end
        end
        PH_SP_A: begin
          scl_drv_next = 1'b0;
          phase_next   = PH_SP_B;
        end
        PH_SP_B: begin
          sda_drv_next = 1'b0;
          phase_next   = PH_SP_C;
        end
        default: begin
          // end of stop
          phase_next       = PH_IDLE;
          last_status_next = pending;
          if (pending == ST_OK && is_read) begin
            read_word_next = receive_accum;
          end
          done = 1'b1;
        end
      endcase
    end

    if (tx_go) begin
      byte_shift_next = tx_byte;
      bit_index_next  = '0;
      sda_drv_next    = !tx_byte[7];
      phase_next      = PH_TX_LO;
    end
    if (rx_go) begin
      sda_drv_next    = 1'b0;
      bit_index_next  = '0;
      byte_shift_next = '0;
      phase_next      = PH_RX_LO;
    end
    if (stop_go) begin
      pending_next = stop_code;
      scl_drv_next = 1'b1;
      sda_drv_next = 1'b1;
      phase_next   = PH_SP_A;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_IDLE;
      half_period_count <= '0;
      bit_index         <= '0;
      byte_index        <= '0;
      byte_shift        <= '0;
      address_latch     <= '0;
      data_latch        <= '0;
      receive_accum     <= '0;
      is_read           <= 1'b0;
      last_status       <= ST_OK;
      stage             <= STG_DEV_W;
      pending           <= ST_OK;
      act_dev           <= '0;
      act_nreg          <= CNT_W'(1);
      act_ndata         <= CNT_W'(1);
      act_span          <= SPAN_W'(1);
      scl_drv           <= 1'b0;
      sda_drv           <= 1'b0;
      read_word         <= '0;
    end else if (step) begin
      phase             <= phase_next;
      half_period_count <= half_period_count_next;
      bit_index         <= bit_index_next;
      byte_index        <= byte_index_next;
      byte_shift        <= byte_shift_next;
      address_latch     <= address_latch_next;
      data_latch        <= data_latch_next;
      receive_accum     <= receive_accum_next;
      is_read           <= is_read_next;
      last_status       <= last_status_next;
      stage             <= stage_next;
      pending           <= pending_next;
      act_dev           <= act_dev_next;
      act_nreg          <= act_nreg_next;
      act_ndata         <= act_ndata_next;
      act_span          <= act_span_next;
      scl_drv           <= scl_drv_next;
      sda_drv           <= sda_drv_next;
      read_word         <= read_word_next;
    end
  end

  assign res_next.scl_low   = scl_drv_next;
  assign res_next.sda_low   = sda_drv_next;
  assign res_next.busy_res  = (phase_next != PH_IDLE);
  assign res_next.done_res  = done;
  assign res_next.status    = last_status_next;
  assign res_next.read_data = read_word_next;

endmodule

// File: src/i2c_register_access_master_unit.sv
`timescale 1ns / 1ps

// I2C register-access master. Every command beat is one tick of the bus
// sequencer and yields exactly one result beat carrying the pin drives,
// busy/done flags, status and last read word after that tick. A beat is taken
// every cycle and its result appears in the output register in the cycle
// after; only a stalled, full output register holds the command side back.
// Bus timing counts beats, not clocks: each half-phase spans the selected delay
// (125, 50, 3 or 0) plus one beats. The user writes configuration through
// the APB port while no transaction is running; the block does not enforce it.
module i2c_register_access_master_unit
  import i2cram_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_stall,
  input  cmd_t               cmd,
  output logic               res_valid,
  input  logic               res_stall,
  output res_t               res,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  cfg_t cfg;
  res_t res_next;
  logic step;

  assign cmd_stall = res_valid && res_stall;
  assign step      = cmd_valid && !cmd_stall;

  i2cram_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  i2cram_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .cmd      (cmd),
    .cfg      (cfg),
    .res_next (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (step) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res <= res_next;
    end
  end

`ifndef SYNTHESIS
  a_step_fills_output : assert property (@(posedge clk) disable iff (rst)
    step |=> res_valid)
    else $error("accepted command beat left no result beat");

  a_done_not_busy : assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.done_res) |-> !res.busy_res)
    else $error("done flagged while still busy");

  a_idle_released : assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res.busy_res) |-> (!res.scl_low && !res.sda_low))
    else $error("bus lines driven while idle");
`endif

endmodule
